// ===== rtl/core/mrc_pkg.sv =====
// shared types, codes and constants of the modbus rtu reply checker
// no dependencies; imported by mrc_ctrl, mrc_dp and the top level
package mrc_pkg;

	// crc-16 as used on modbus rtu lines
	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'hA001;

	// function codes and the exception flag
	localparam logic [7:0] FUNC_READ  = 8'h03;
	localparam logic [7:0] FUNC_WRITE = 8'h10;
	localparam logic [7:0] EXC_FLAG   = 8'h80;

	// header bytes kept from the start of each frame
	localparam int HDR_DEPTH = 6;
	localparam int HDR_AW    = 3;

	// word counter width, follows the 5 bit register count
	localparam int CNT_W = 5;

	// register indexes on the configuration port (paddr[3:2])
	localparam logic [1:0] REG_SLAVE_ADDR = 2'd0;
	localparam logic [1:0] REG_OP_KIND    = 2'd1;
	localparam logic [1:0] REG_START_REG  = 2'd2;
	localparam logic [1:0] REG_REG_COUNT  = 2'd3;

	// result status codes
	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_CRC     = 2'd1,
		ST_EXC     = 2'd2,
		ST_INVALID = 2'd3
	} mrc_status_t;

	// configuration seen by the datapath
	typedef struct packed {
		logic [7:0]       slave_address;
		logic             operation_kind;
		logic [15:0]      start_register;
		logic [CNT_W-1:0] register_count;
	} mrc_cfg_t;

	// commands from the controller
	typedef struct packed {
		logic take_byte;
		logic check;
		logic load_word;
		logic load_status;
	} mrc_cmd_t;

	// status back to the controller
	typedef struct packed {
		logic words_out;
		logic last_word;
	} mrc_stat_t;

	// one byte through the reflected crc, one shift per bit
	function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] data);
		logic [15:0] c;
		c = crc ^ {8'h00, data};
		for (int i = 0; i < 8; i++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

endpackage

// ===== rtl/core/mrc_ctrl.sv =====
// controller of the reply checker: frame sequencing and output valid
// depends on mrc_pkg; drives mrc_dp through mrc_cmd_t
module mrc_ctrl
	import mrc_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      s_tvalid,
	input  logic      s_tlast,
	output logic      s_tready,
	output logic      m_tvalid,
	input  logic      m_tready,
	input  mrc_stat_t stat,
	output mrc_cmd_t  cmd
);

	typedef enum logic [1:0] {
		IDLE,
		CHECK,
		WORDS,
		REPORT
	} state_t;

	state_t state_q;
	logic   m_tvalid_q;
	logic   out_free;

	// output register can take a new request
	assign out_free = !m_tvalid_q || m_tready;

	// commands decoded from the state
	always_comb begin
		cmd             = '0;
		cmd.take_byte   = (state_q == IDLE) && s_tvalid;
		cmd.check       = (state_q == CHECK);
		cmd.load_word   = (state_q == WORDS) && out_free;
		cmd.load_status = (state_q == REPORT) && out_free;
	end

	assign s_tready = (state_q == IDLE);
	assign m_tvalid = m_tvalid_q;

	// state and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= IDLE;
			m_tvalid_q <= 1'b0;
		end else begin
			if (cmd.load_word || cmd.load_status) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				IDLE: begin
					if (cmd.take_byte && s_tlast) begin
						state_q <= CHECK;
					end
				end
				CHECK: begin
					state_q <= stat.words_out ? WORDS : REPORT;
				end
				WORDS: begin
					if (cmd.load_word && stat.last_word) begin
						state_q <= IDLE;
					end
				end
				REPORT: begin
					if (cmd.load_status) begin
						state_q <= IDLE;
					end
				end
				default: begin
					state_q <= IDLE;
				end
			endcase
		end
	end

endmodule

// ===== rtl/core/mrc_dp.sv =====
// datapath of the reply checker: crc, byte count, header, word store, result register
// depends on mrc_pkg; commanded by mrc_ctrl
module mrc_dp
	import mrc_pkg::*;
#(
	parameter int MAX_REGISTERS   = 16,
	parameter int MAX_FRAME_BYTES = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  mrc_cfg_t    cfg,
	input  mrc_cmd_t    cmd,
	input  logic [7:0]  rx_byte,
	output mrc_stat_t   stat,
	output logic [15:0] out_value,
	output logic [3:0]  out_index,
	output logic [1:0]  out_status,
	output logic [7:0]  out_exc,
	output logic        out_last
);

	localparam int CW = $clog2(MAX_FRAME_BYTES + 1);
	localparam int AW = (MAX_REGISTERS > 1) ? $clog2(MAX_REGISTERS) : 1;
	localparam int LW = 10;

	logic [15:0]      crc_q;
	logic [CW-1:0]    byte_count_q;
	logic [7:0]       high_byte_hold_q;
	logic             overflow_q;
	logic [7:0]       hdr_q [HDR_DEPTH];
	logic [15:0]      word_mem [MAX_REGISTERS];
	logic [15:0]      rd_data_q;
	logic [CNT_W-1:0] widx_q;
	mrc_status_t      status_q;
	logic [7:0]       exc_q;

	logic             room;
	logic [CW-1:0]    off;
	logic             word_we;
	logic [AW-1:0]    word_waddr;
	logic [CNT_W-1:0] widx_next;
	logic [AW-1:0]    word_raddr;
	logic [7:0]       func;
	logic [LW-1:0]    n_ext;
	logic [LW-1:0]    read_len;
	logic             bad_count;
	logic             exc_hit;
	logic             read_ok;
	logic             write_ok;
	mrc_status_t      status_d;

	// byte position bookkeeping
	assign room       = 32'(byte_count_q) < MAX_FRAME_BYTES;
	assign off        = byte_count_q - CW'(3);
	assign word_we    = cmd.take_byte && room && (byte_count_q >= CW'(3)) && off[0]
	                    && (32'(off >> 1) < MAX_REGISTERS);
	assign word_waddr = AW'(off >> 1);

	// running frame state, cleared once the frame is checked
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q            <= CRC_INIT;
			byte_count_q     <= '0;
			high_byte_hold_q <= '0;
			overflow_q       <= 1'b0;
		end else if (cmd.check) begin
			crc_q            <= CRC_INIT;
			byte_count_q     <= '0;
			high_byte_hold_q <= '0;
			overflow_q       <= 1'b0;
		end else if (cmd.take_byte) begin
			crc_q <= crc16_byte(crc_q, rx_byte);
			if (room) begin
				byte_count_q <= byte_count_q + CW'(1);
				if ((byte_count_q >= CW'(3)) && !off[0]) begin
					high_byte_hold_q <= rx_byte;
				end
			end else begin
				overflow_q <= 1'b1;
			end
		end
	end

	// header capture
	always_ff @(posedge clk) begin
		if (cmd.take_byte && (byte_count_q < CW'(HDR_DEPTH))) begin
			hdr_q[byte_count_q[HDR_AW-1:0]] <= rx_byte;
		end
	end

	// word read address, one ahead while words are being sent
	assign widx_next  = widx_q + CNT_W'(1);
	always_comb begin
		word_raddr = AW'(widx_q);
		if (cmd.check) begin
			word_raddr = '0;
		end else if (cmd.load_word) begin
			word_raddr = (32'(widx_next) < MAX_REGISTERS) ? AW'(widx_next) : '0;
		end
	end

	// word store, one write and one registered read a cycle
	always_ff @(posedge clk) begin
		if (word_we) begin
			word_mem[word_waddr] <= {high_byte_hold_q, rx_byte};
		end
		rd_data_q <= word_mem[word_raddr];
	end

	// end of frame checks
	assign func      = cfg.operation_kind ? FUNC_WRITE : FUNC_READ;
	assign n_ext     = LW'(byte_count_q);
	assign read_len  = LW'(5) + (LW'(cfg.register_count) << 1);
	assign bad_count = (cfg.register_count == '0) || (32'(cfg.register_count) > MAX_REGISTERS);
	assign exc_hit   = (n_ext >= LW'(5)) && (hdr_q[0] == cfg.slave_address)
	                   && (hdr_q[1] == (func | EXC_FLAG));
	assign read_ok   = (n_ext == read_len) && (hdr_q[0] == cfg.slave_address)
	                   && (hdr_q[1] == FUNC_READ) && (hdr_q[2] == {2'b00, cfg.register_count, 1'b0});
	assign write_ok  = (n_ext == LW'(8)) && (hdr_q[0] == cfg.slave_address)
	                   && (hdr_q[1] == FUNC_WRITE)
	                   && (hdr_q[2] == cfg.start_register[15:8])
	                   && (hdr_q[3] == cfg.start_register[7:0])
	                   && (hdr_q[4] == 8'h00) && (hdr_q[5] == {3'b000, cfg.register_count});

	always_comb begin
		status_d = ST_OK;
		if (overflow_q || bad_count) begin
			status_d = ST_INVALID;
		end else if ((n_ext < LW'(4)) || (crc_q != 16'h0000)) begin
			status_d = ST_CRC;
		end else if (exc_hit) begin
			status_d = ST_EXC;
		end else if (!cfg.operation_kind) begin
			if (!read_ok) begin
				status_d = ST_INVALID;
			end
		end else if (!write_ok) begin
			status_d = ST_INVALID;
		end
	end

	assign stat.words_out = (status_d == ST_OK) && !cfg.operation_kind;
	assign stat.last_word = (widx_q == (cfg.register_count - CNT_W'(1)));

	// word counter for the read results
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			widx_q <= '0;
		end else if (cmd.check) begin
			widx_q <= '0;
		end else if (cmd.load_word) begin
			widx_q <= widx_next;
		end
	end

	// verdict held for the status result
	always_ff @(posedge clk) begin
		if (cmd.check) begin
			status_q <= status_d;
			exc_q    <= (status_d == ST_EXC) ? hdr_q[2] : 8'h00;
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.load_word) begin
			out_value  <= rd_data_q;
			out_index  <= widx_q[3:0];
			out_status <= ST_OK;
			out_exc    <= 8'h00;
			out_last   <= stat.last_word;
		end else if (cmd.load_status) begin
			out_value  <= 16'h0000;
			out_index  <= 4'h0;
			out_status <= status_q;
			out_exc    <= exc_q;
			out_last   <= 1'b1;
		end
	end

endmodule

// ===== rtl/core/modbus_rtu_response_checker.sv =====
// top level of the modbus rtu reply checker: configuration registers and assertions
// depends on mrc_pkg, mrc_ctrl and mrc_dp
//
// Usage
//   Slave side: one reply byte per request on s_tdata[7:0], s_tlast on the last
//   byte of the frame. Master side: one result per request, m_tlast on the last
//   result of a frame. Four registers on the apb port: slave address (0x0),
//   operation kind (0x4), start register (0x8), register count (0xc).
//   A byte without end mark is taken in IDLE: its crc is folded into the running
//   crc as it is taken and s_tready stays high. The closing byte is followed by
//   the CHECK state, then either a single status result or, for a good read, one
//   word a cycle while the sink is ready, from the word store (one registered read
//   port). s_tready is low from the closing byte until the last result is loaded.
//   The result register is loaded in the WORDS or REPORT state that follows CHECK.
//   A stalled sink holds the result register and, while words are sent, keeps
//   s_tready low; after a status result bytes of the next frame are still
//   taken, and its result waits until the register is free.
//   Reset clears the crc, counters, flags and registers to their defaults; the
//   header and word stores hold whatever they last saw and are read only after
//   being written by the current frame.
module modbus_rtu_response_checker
	import mrc_pkg::*;
#(
	parameter int MAX_REGISTERS   = 16,
	parameter int MAX_FRAME_BYTES = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	// apb configuration port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// reply bytes
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] rx_byte
	input  logic        s_tlast,
	// results
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [15:0] register_value, [19:16] register_index,
	                               // [27:20] exc_code, [31:28] zero
	output logic [1:0]  m_tuser,   // [1:0] status
	output logic        m_tlast
);

	mrc_cfg_t    cfg_q;
	mrc_cmd_t    cmd;
	mrc_stat_t   stat;
	logic        cfg_we;
	logic [15:0] out_value;
	logic [3:0]  out_index;
	logic [1:0]  out_status;
	logic [7:0]  out_exc;
	logic        out_last_w;

	// configuration writes
	assign pready = 1'b1;
	assign cfg_we = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.slave_address  <= 8'd1;
			cfg_q.operation_kind <= 1'b0;
			cfg_q.start_register <= 16'd100;
			cfg_q.register_count <= CNT_W'(2);
		end else if (cfg_we) begin
			case (paddr[3:2])
				REG_SLAVE_ADDR: cfg_q.slave_address  <= pwdata[7:0];
				REG_OP_KIND:    cfg_q.operation_kind <= pwdata[0];
				REG_START_REG:  cfg_q.start_register <= pwdata[15:0];
				REG_REG_COUNT:  cfg_q.register_count <= pwdata[CNT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// register read back
	always_comb begin
		case (paddr[3:2])
			REG_SLAVE_ADDR: prdata = {24'h0, cfg_q.slave_address};
			REG_OP_KIND:    prdata = {31'h0, cfg_q.operation_kind};
			REG_START_REG:  prdata = {16'h0, cfg_q.start_register};
			REG_REG_COUNT:  prdata = {{(32-CNT_W){1'b0}}, cfg_q.register_count};
			default:        prdata = 32'h0;
		endcase
	end

	mrc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tlast  (s_tlast),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	mrc_dp #(
		.MAX_REGISTERS   (MAX_REGISTERS),
		.MAX_FRAME_BYTES (MAX_FRAME_BYTES)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.cmd        (cmd),
		.rx_byte    (s_tdata),
		.stat       (stat),
		.out_value  (out_value),
		.out_index  (out_index),
		.out_status (out_status),
		.out_exc    (out_exc),
		.out_last   (out_last_w)
	);

	// result packing
	assign m_tdata = {4'h0, out_exc, out_index, out_value};
	assign m_tuser = out_status;
	assign m_tlast = out_last_w;

	// frame end stops further bytes in the CHECK state
	a_eof_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tlast |=> !s_tready)
		else $error("byte taken straight after a frame end");

	// result register is never overwritten while still held
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_word || cmd.load_status |-> !m_tvalid || m_tready)
		else $error("result overwritten before it was taken");

	// a failure status is always the single closing result
	a_status_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser != ST_OK) |-> m_tlast)
		else $error("failure status without last mark");

	// an exception code only travels with the exception status
	a_exc_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[27:20] != 8'h00) |-> (m_tuser == ST_EXC))
		else $error("exception code on a non exception result");

endmodule

// ===== tb/modbus_rtu_response_checker_tb.sv =====
// self-checking testbench of the modbus rtu reply checker: streams reply frames, predicts results
// depends on mrc_pkg and modbus_rtu_response_checker
`timescale 1ns / 1ps

module modbus_rtu_response_checker_tb
	import mrc_pkg::*;
();

	localparam int MAX_WORDS = 16;
	localparam int FRAME_CAP = 64;
	localparam int LONG_HOLD = 400;

	// one reply byte request and one expected result
	typedef struct {
		logic [7:0] data;
		logic       last;
	} rx_req_t;

	typedef struct {
		logic [15:0] value;
		logic [3:0]  index;
		mrc_status_t status;
		logic [7:0]  exc;
		logic        last;
	} reply_t;

	typedef enum int {FK_GOOD, FK_EXC, FK_BITFLIP, FK_BADHDR, FK_NOISE, FK_OVERRUN} frame_kind_t;

	logic        clk;
	logic        arst_n   = 1'b0;
	logic        psel     = 1'b0;
	logic        penable  = 1'b0;
	logic        pwrite   = 1'b0;
	logic [3:0]  paddr    = '0;
	logic [31:0] pwdata   = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata  = '0;  // [7:0] rx_byte
	logic        s_tlast  = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;        // [15:0] register_value, [19:16] register_index,
	                             // [27:20] exc_code, [31:28] zero
	logic [1:0]  m_tuser;        // [1:0] status
	logic        m_tlast;

	modbus_rtu_response_checker dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// stimulus and expectation stores
	rx_req_t    byte_queue[$];
	reply_t     expected_results[$];
	logic [7:0] fb[$];
	int         fail_count = 0;

	// idling controls
	int   send_idle_pct  = 0;
	int   sink_stall_pct = 0;
	logic hold_trigger   = 1'b0;
	logic hold_seen      = 1'b0;
	int   hold_left      = 0;

	// predicted configuration
	logic [7:0]  cfg_slave = 8'd1;
	logic        cfg_write = 1'b0;
	logic [15:0] cfg_start = 16'd100;
	logic [4:0]  cfg_count = 5'd2;

	// predicted frame state
	logic [15:0] crc_run = CRC_INIT;
	int          nbytes  = 0;
	logic [7:0]  hdr[HDR_DEPTH];
	logic [15:0] words[MAX_WORDS];
	logic [7:0]  hi_hold = 8'h00;
	logic        ovf     = 1'b0;

	// reflected crc-16, bit serial
	function automatic logic [15:0] crc_step(logic [15:0] c, logic [7:0] b);
		c = c ^ {8'h00, b};
		repeat (8) c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		return c;
	endfunction

	// verdict on a closed frame
	function automatic mrc_status_t judge_frame();
		logic [7:0] fn;
		fn = cfg_write ? FUNC_WRITE : FUNC_READ;
		if (ovf)
			return ST_INVALID;
		if (cfg_count == 0 || cfg_count > MAX_WORDS)
			return ST_INVALID;
		if (nbytes < 4 || crc_run != 16'h0000)
			return ST_CRC;
		if (nbytes >= 5 && hdr[0] == cfg_slave && hdr[1] == (fn | EXC_FLAG))
			return ST_EXC;
		if (!cfg_write) begin
			if (nbytes != 5 + 2 * cfg_count || hdr[0] != cfg_slave || hdr[1] != FUNC_READ ||
			    hdr[2] != 8'(2 * cfg_count))
				return ST_INVALID;
		end else begin
			if (nbytes != 8 || hdr[0] != cfg_slave || hdr[1] != FUNC_WRITE ||
			    hdr[2] != cfg_start[15:8] || hdr[3] != cfg_start[7:0] ||
			    hdr[4] != 8'h00 || hdr[5] != {3'b000, cfg_count})
				return ST_INVALID;
		end
		return ST_OK;
	endfunction

	// fold one accepted byte into the frame state, queue results at frame end
	function automatic void absorb_byte(logic [7:0] b, logic eof);
		int          off;
		mrc_status_t st;
		reply_t      r;
		crc_run = crc_step(crc_run, b);
		if (nbytes < FRAME_CAP) begin
			if (nbytes < HDR_DEPTH)
				hdr[nbytes] = b;
			if (nbytes >= 3) begin
				off = nbytes - 3;
				if (off % 2 == 0)
					hi_hold = b;
				else if (off / 2 < MAX_WORDS)
					words[off / 2] = {hi_hold, b};
			end
			nbytes++;
		end else begin
			ovf = 1'b1;
		end
		if (!eof)
			return;
		st = judge_frame();
		if (st == ST_OK && !cfg_write) begin
			for (int i = 0; i < cfg_count; i++) begin
				r = '{words[i], 4'(i), ST_OK, 8'h00, i == cfg_count - 1};
				expected_results.push_back(r);
			end
		end else begin
			r = '{16'h0000, 4'h0, st, (st == ST_EXC) ? hdr[2] : 8'h00, 1'b1};
			expected_results.push_back(r);
		end
		crc_run = CRC_INIT;
		nbytes  = 0;
		hi_hold = 8'h00;
		ovf     = 1'b0;
	endfunction

	// reply byte driver, predictor fed on each accepted request
	always @(posedge clk) begin
		rx_req_t item;
		if (s_tvalid && s_tready)
			absorb_byte(s_tdata, s_tlast);
		if (!s_tvalid || s_tready) begin
			if (byte_queue.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
				item = byte_queue.pop_front();
				s_tvalid <= 1'b1;
				s_tdata  <= item.data;
				s_tlast  <= item.last;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// result sink readiness, with a long hold-off on request
	always @(posedge clk) begin
		if (hold_trigger != hold_seen) begin
			hold_seen = hold_trigger;
			hold_left = LONG_HOLD;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99, 0) >= sink_stall_pct);
		end
	end

	// result monitor
	always @(posedge clk) begin
		reply_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_results.size() == 0) begin
				$error("unexpected result: register_value %h status %0d", m_tdata[15:0], m_tuser);
				fail_count++;
			end else begin
				want = expected_results.pop_front();
				if (m_tdata[15:0] != want.value) begin
					$error("register_value: expected %h, got %h", want.value, m_tdata[15:0]);
					fail_count++;
				end
				if (m_tdata[19:16] != want.index) begin
					$error("register_index: expected %0d, got %0d", want.index, m_tdata[19:16]);
					fail_count++;
				end
				if (m_tuser != want.status) begin
					$error("status: expected %0d, got %0d", want.status, m_tuser);
					fail_count++;
				end
				if (m_tdata[27:20] != want.exc) begin
					$error("exc_code: expected %h, got %h", want.exc, m_tdata[27:20]);
					fail_count++;
				end
				if (m_tlast != want.last) begin
					$error("last_result: expected %0d, got %0d", want.last, m_tlast);
					fail_count++;
				end
			end
		end
	end

	// register write over apb: setup, access, predicted copy updated at the write edge
	task automatic write_reg(logic [1:0] idx, logic [31:0] val);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		case (idx)
		REG_SLAVE_ADDR: cfg_slave = val[7:0];
		REG_OP_KIND:    cfg_write = val[0];
		REG_START_REG:  cfg_start = val[15:0];
		REG_REG_COUNT:  cfg_count = val[4:0];
		default: ;
		endcase
	endtask

	task automatic set_config(logic [7:0] slave, logic op, logic [15:0] start, logic [4:0] cnt);
		write_reg(REG_SLAVE_ADDR, {24'h0, slave});
		write_reg(REG_OP_KIND, {31'h0, op});
		write_reg(REG_START_REG, {16'h0, start});
		write_reg(REG_REG_COUNT, {27'h0, cnt});
	endtask

	// 0 none, 1 sender idle, 2 receiver stalls, 3 both
	task automatic set_idling(int mode);
		@(posedge clk);
		send_idle_pct  <= (mode == 1) ? 78 : (mode == 3) ? 18 : 0;
		sink_stall_pct <= (mode == 2) ? 78 : (mode == 3) ? 18 : 0;
	endtask

	// wait until every byte is taken and every result has come, then let the block settle
	task automatic wait_quiet();
		while (byte_queue.size() != 0 || s_tvalid || expected_results.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// frame building
	function automatic logic [7:0] data_byte();
		case ($urandom_range(3, 0))
		0: return 8'h00;
		1: return 8'hFF;
		default: return 8'($urandom);
		endcase
	endfunction

	function automatic void send_raw();
		rx_req_t item;
		for (int i = 0; i < fb.size(); i++) begin
			item = '{fb[i], i == fb.size() - 1};
			byte_queue.push_back(item);
		end
	endfunction

	function automatic void add_crc();
		logic [15:0] c;
		c = CRC_INIT;
		foreach (fb[i]) c = crc_step(c, fb[i]);
		fb.push_back(c[7:0]);
		fb.push_back(c[15:8]);
	endfunction

	function automatic void seal_and_send();
		add_crc();
		send_raw();
	endfunction

	function automatic void make_reply(frame_kind_t kind);
		int         q;
		int         pos;
		logic [7:0] fn;
		q  = (cfg_count >= 1 && cfg_count <= MAX_WORDS) ? int'(cfg_count)
		                                                : int'($urandom_range(MAX_WORDS, 1));
		fn = cfg_write ? FUNC_WRITE : FUNC_READ;
		fb.delete();
		case (kind)
		FK_NOISE: begin
			repeat ($urandom_range(12, 1)) fb.push_back(8'($urandom));
			send_raw();
		end
		FK_OVERRUN: begin
			repeat ($urandom_range(FRAME_CAP + 6, FRAME_CAP + 1)) fb.push_back(8'($urandom));
			send_raw();
		end
		FK_EXC: begin
			// sometimes a foreign address, the other function code or no code byte at all
			fb.push_back(($urandom_range(3, 0) == 0) ? 8'($urandom) : cfg_slave);
			fb.push_back((($urandom_range(3, 0) == 0) ? (FUNC_READ ^ FUNC_WRITE ^ fn) : fn) | EXC_FLAG);
			if ($urandom_range(4, 0) != 0)
				fb.push_back(data_byte());
			seal_and_send();
		end
		default: begin
			fb.push_back(cfg_slave);
			fb.push_back(fn);
			if (!cfg_write) begin
				fb.push_back(8'(2 * q));
				repeat (2 * q) fb.push_back(data_byte());
			end else begin
				fb.push_back(cfg_start[15:8]);
				fb.push_back(cfg_start[7:0]);
				fb.push_back(8'h00);
				fb.push_back(8'(q));
			end
			// one byte before the crc wrong, or the length off by one
			if (kind == FK_BADHDR) begin
				pos = $urandom_range(fb.size(), 0);
				if (pos == fb.size()) begin
					if ($urandom_range(1, 0) == 1)
						fb.push_back(data_byte());
					else
						void'(fb.pop_back());
				end else begin
					fb[pos] = fb[pos] ^ 8'($urandom_range(255, 1));
				end
			end
			add_crc();
			if (kind == FK_BITFLIP) begin
				pos = $urandom_range(fb.size() - 1, 0);
				fb[pos] = fb[pos] ^ 8'(1 << $urandom_range(7, 0));
			end
			send_raw();
		end
		endcase
	endfunction

	function automatic frame_kind_t pick_kind();
		int r;
		r = $urandom_range(99, 0);
		if (r < 40) return FK_GOOD;
		if (r < 55) return FK_EXC;
		if (r < 70) return FK_BITFLIP;
		if (r < 88) return FK_BADHDR;
		return FK_NOISE;
	endfunction

	// run sequence
	initial begin
		int budget;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed frames under the reset settings
		fb = {8'h01, FUNC_READ, 8'h04, 8'hFF, 8'hFF, 8'h00, 8'h00};
		seal_and_send();
		fb = {8'hFF};
		send_raw();
		fb = {8'h01, FUNC_READ | EXC_FLAG, 8'hFF};
		seal_and_send();
		fb = {8'h00, 8'h00, 8'h00, 8'h00};
		send_raw();
		wait_quiet();

		// directed write reply at the register extremes
		set_config(8'd247, 1'b1, 16'hFFFF, 5'd16);
		fb = {8'd247, FUNC_WRITE, 8'hFF, 8'hFF, 8'h00, 8'd16};
		seal_and_send();
		wait_quiet();

		// random phases, each with its own settings and idling
		for (int p = 0; p < 5; p++) begin
			set_config((p == 0) ? 8'd0 : (p == 1) ? 8'd247 : 8'($urandom_range(247, 0)),
			           (p == 2) ? 1'b0 : 1'(p),
			           (p == 0) ? 16'h0000 : (p == 1) ? 16'hFFFF : 16'($urandom),
			           (p == 0) ? 5'd1 : (p <= 2) ? 5'd16 : 5'($urandom_range(MAX_WORDS, 1)));
			set_idling(p % 4);
			budget = 0;
			if (p == 2) begin
				make_reply(FK_OVERRUN);
				make_reply(FK_GOOD);
			end
			while (budget < 10) begin
				make_reply(pick_kind());
				budget += fb.size();
			end
			wait_quiet();
		end

		// register counts out of range spoil every frame
		set_idling(0);
		set_config(8'd1, 1'b0, 16'd100, 5'd0);
		make_reply(FK_GOOD);
		make_reply(FK_EXC);
		wait_quiet();
		set_config(8'd1, 1'b1, 16'd100, 5'd31);
		make_reply(FK_GOOD);
		make_reply(FK_NOISE);
		wait_quiet();
		set_config(8'd1, 1'b0, 16'd100, 5'd17);
		make_reply(FK_GOOD);
		wait_quiet();

		// sink held off while good reads keep arriving, so the input backs up
		set_config(8'($urandom_range(247, 0)), 1'b0, 16'($urandom), 5'd4);
		@(posedge clk);
		hold_trigger <= ~hold_trigger;
		repeat (4) make_reply(FK_GOOD);
		wait_quiet();

		repeat (20) @(posedge clk);
		if (fail_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	// watchdog
	initial begin
		#2000000;
		$display("*** FAILED ***");
		$finish;
	end

endmodule
